@@ rtl/mandel_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, register codes, the point record that travels down the
// iteration chain, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mandel_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int ITER_CELLS = 255;
  localparam int FRAC_BITS  = 28;

  localparam int NUM_CELLS = ITER_CELLS + 1;
  localparam int CNT_W     = $clog2(ITER_CELLS + 1);
  localparam int COORD_W   = 10;
  localparam int WORD_W    = 32;
  localparam int STEP_W    = 28;
  localparam int LIMIT_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = COORD_W + STEP_W;
  localparam int WIDE_W    = 2 * WORD_W + 2;

  localparam logic signed [WORD_W-1:0] CMIN_REAL_RST = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] CMIN_IMAG_RST = -32'sd268435456;
  localparam logic [STEP_W-1:0]        STEP_REAL_RST = 28'd1260260;
  localparam logic [STEP_W-1:0]        STEP_IMAG_RST = 28'd1120816;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST     = 8'd255;

  localparam logic [2*WORD_W:0] RADIUS_SQ =
    {{(2*WORD_W-2){1'b0}}, 3'b100} << (2 * FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CMIN_REAL = 3'd0,
    REG_CMIN_IMAG = 3'd1,
    REG_STEP_REAL = 3'd2,
    REG_STEP_IMAG = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                     run;
    logic                     esc;
    logic [CNT_W-1:0]         iter;
    logic signed [WORD_W-1:0] c_re;
    logic signed [WORD_W-1:0] c_im;
    logic signed [WORD_W-1:0] re;
    logic signed [WORD_W-1:0] im;
  } point_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x);
    logic [WIDE_W-WORD_W:0] top;
    top = x[WIDE_W-1:WORD_W-1];
    if (top == '0 || top == '1) begin
      return x[WORD_W-1:0];
    end else if (x[WIDE_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/mandel_map.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot coordinate mapper
// Clamps the pixel position and forms c = cmin + coordinate * step in two
// stages: a registered product, then a saturated sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandel_map (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_vld,
  input  logic [mandel_pkg::COORD_W-1:0]        column,
  input  logic [mandel_pkg::COORD_W-1:0]        row,
  input  logic signed [mandel_pkg::WORD_W-1:0]  cmin_real,
  input  logic signed [mandel_pkg::WORD_W-1:0]  cmin_imag,
  input  logic [mandel_pkg::STEP_W-1:0]         step_real,
  input  logic [mandel_pkg::STEP_W-1:0]         step_imag,
  output logic                                  out_vld,
  output mandel_pkg::point_t                    out_pt
);
  import mandel_pkg::*;

  logic [COORD_W-1:0]        col_c;
  logic [COORD_W-1:0]        row_c;
  logic                      prod_vld;
  logic [PROD_W-1:0]         prod_re;
  logic [PROD_W-1:0]         prod_im;
  logic signed [WIDE_W-1:0]  sum_re;
  logic signed [WIDE_W-1:0]  sum_im;

  always_comb begin
    col_c = (32'(column) >= MAX_COLS) ? COORD_W'(MAX_COLS - 1) : column;
    row_c = (32'(row) >= MAX_ROWS) ? COORD_W'(MAX_ROWS - 1) : row;
    sum_re = WIDE_W'(cmin_real) + WIDE_W'(prod_re);
    sum_im = WIDE_W'(cmin_imag) + WIDE_W'(prod_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else if (adv) begin
      prod_vld <= in_vld;
      out_vld  <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_re     <= PROD_W'(col_c) * PROD_W'(step_real);
      prod_im     <= PROD_W'(row_c) * PROD_W'(step_imag);
      out_pt.run  <= 1'b1;
      out_pt.esc  <= 1'b0;
      out_pt.iter <= '0;
      out_pt.c_re <= sat_word(sum_re);
      out_pt.c_im <= sat_word(sum_im);
      out_pt.re   <= '0;
      out_pt.im   <= '0;
    end
  end

endmodule

@@ rtl/mandel_cell.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot iteration cell
// One step of z = z^2 + c: the squares and cross product are registered,
// then the escape test and the saturated update are registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandel_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [mandel_pkg::CNT_W-1:0]   idx,
  input  logic [mandel_pkg::LIMIT_W-1:0] limit,
  input  logic                           in_vld,
  input  mandel_pkg::point_t             in_pt,
  output logic                           out_vld,
  output mandel_pkg::point_t             out_pt
);
  import mandel_pkg::*;

  logic                       mul_vld;
  point_t                     mul_pt;
  logic signed [2*WORD_W-1:0] rr;
  logic signed [2*WORD_W-1:0] ii;
  logic signed [2*WORD_W-1:0] ri;
  logic [2*WORD_W:0]          mag;
  logic                       in_radius;
  logic signed [WIDE_W-1:0]   diff;
  logic signed [WIDE_W-1:0]   nre;
  logic signed [WIDE_W-1:0]   nim;
  point_t                     pt_next;

  always_comb begin
    mag       = {1'b0, rr} + {1'b0, ii};
    in_radius = mag < RADIUS_SQ;
    diff      = WIDE_W'(rr) - WIDE_W'(ii);
    nre       = (diff >>> FRAC_BITS) + WIDE_W'(mul_pt.c_re);
    nim       = (WIDE_W'(ri) >>> (FRAC_BITS - 1)) + WIDE_W'(mul_pt.c_im);
    pt_next   = mul_pt;
    if (mul_pt.run) begin
      if (!in_radius) begin
        pt_next.run = 1'b0;
        pt_next.esc = 1'b1;
      end else if (LIMIT_W'(idx) < limit) begin
        pt_next.re   = sat_word(nre);
        pt_next.im   = sat_word(nim);
        pt_next.iter = CNT_W'(mul_pt.iter + 1'b1);
      end else begin
        pt_next.run = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      mul_vld <= in_vld;
      out_vld <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_pt <= in_pt;
      rr     <= in_pt.re * in_pt.re;
      ii     <= in_pt.im * in_pt.im;
      ri     <= in_pt.re * in_pt.im;
      out_pt <= pt_next;
    end
  end

endmodule

@@ rtl/mandelbrot_escape_time.sv @@
// A request passes the mapper, then the iteration cells, then the result register.
// Throughput: one request per cycle while results are taken; the chain of
// ITER_CELLS + 1 two-stage iteration cells moves as a whole and holds on back-pressure.
// Reset clears all valid flags and loads the configuration registers with their
// default view; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine
// Maps each pixel to a point c and runs it through a chain of iteration cells,
// returning the iteration count at escape or zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mandel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mandel_pkg::WORD_W-1:0]      cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [mandel_pkg::COORD_W-1:0]     column,
  input  logic [mandel_pkg::COORD_W-1:0]     row,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [mandel_pkg::LIMIT_W-1:0]     escape_count
);
  import mandel_pkg::*;

  logic signed [WORD_W-1:0] cmin_real;
  logic signed [WORD_W-1:0] cmin_imag;
  logic [STEP_W-1:0]        step_real;
  logic [STEP_W-1:0]        step_imag;
  logic [LIMIT_W-1:0]       iteration_limit;
  logic                     adv;
  logic [NUM_CELLS:0]       vld_chain;
  point_t                   pt_chain [NUM_CELLS+1];
  point_t                   last_pt;

  assign adv         = !result_valid || result_ready;
  assign pixel_ready = adv;
  assign last_pt     = pt_chain[NUM_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cmin_real       <= CMIN_REAL_RST;
      cmin_imag       <= CMIN_IMAG_RST;
      step_real       <= STEP_REAL_RST;
      step_imag       <= STEP_IMAG_RST;
      iteration_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CMIN_REAL:  cmin_real <= cfg_data;
        REG_CMIN_IMAG:  cmin_imag <= cfg_data;
        REG_STEP_REAL:  step_real <= cfg_data[STEP_W-1:0];
        REG_STEP_IMAG:  step_imag <= cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT: iteration_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  mandel_map u_map (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_vld    (pixel_valid && pixel_ready),
    .column    (column),
    .row       (row),
    .cmin_real (cmin_real),
    .cmin_imag (cmin_imag),
    .step_real (step_real),
    .step_imag (step_imag),
    .out_vld   (vld_chain[0]),
    .out_pt    (pt_chain[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mandel_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .idx     (CNT_W'(k)),
      .limit   (iteration_limit),
      .in_vld  (vld_chain[k]),
      .in_pt   (pt_chain[k]),
      .out_vld (vld_chain[k+1]),
      .out_pt  (pt_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vld_chain[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      escape_count <= last_pt.esc ? LIMIT_W'(last_pt.iter) : '0;
    end
  end

endmodule

@@ rtl/mandel_chk.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time port checker
// Watches the request and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandel_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               pixel_valid,
  input logic                               pixel_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic [mandel_pkg::LIMIT_W-1:0]     escape_count
);
  import mandel_pkg::*;

  a_request_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid)
    else $error("Request withdrawn before it was accepted.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(escape_count))
    else $error("Result dropped or changed while stalled.");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    pixel_ready == (!result_valid || result_ready))
    else $error("Request ready does not follow the output register state.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid after reset.");

  a_no_early_result: assert property (@(posedge clk)
    $past(rst) && !rst |-> !result_valid)
    else $error("Result appeared right after reset without a request.");

endmodule

bind mandelbrot_escape_time mandel_chk u_mandel_chk (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .escape_count (escape_count)
);

@@ tb/mandelbrot_escape_time_tb.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine testbench
// Drives pixel requests through a handshake with random gaps and back-pressure.
// A directed table covers the image corners, the iteration-limit extremes,
// saturated coordinates and the escape radius boundary. Random phases follow
// under several complex-plane windows. Every result is checked against its pinned
// count from the table or against a fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
  import mandel_pkg::*;

  localparam int LATENCY = 2 * ITER_CELLS + 5;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_PHASE = 3;
  localparam int MAX_REPORTS = 10;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [WORD_W-1:0] cmin_re;
    logic signed [WORD_W-1:0] cmin_im;
    logic [STEP_W-1:0]        step_re;
    logic [STEP_W-1:0]        step_im;
    logic [LIMIT_W-1:0]       limit;
  } window_t;

  typedef struct packed {
    logic               pinned;
    logic [LIMIT_W-1:0] count;
  } pin_t;

  typedef struct packed {
    window_t            win;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] rw;
    logic               pinned;
    logic [LIMIT_W-1:0] count;
  } probe_t;

  typedef enum {
    PLAN_DEFAULT,
    PLAN_NOISE,
    PLAN_ZOOM_DEEP,
    PLAN_ZOOM_ANY,
    PLAN_ZOOM_ONE,
    PLAN_ZOOM_SHALLOW
  } plan_kind_t;

  localparam plan_kind_t PHASE_PLAN [NUM_PHASES] = '{
    PLAN_DEFAULT, PLAN_ZOOM_ANY, PLAN_NOISE, PLAN_ZOOM_DEEP,
    PLAN_ZOOM_ONE, PLAN_ZOOM_SHALLOW, PLAN_ZOOM_DEEP
  };

  localparam window_t W_RESET =
    '{CMIN_REAL_RST, CMIN_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, LIMIT_RST};
  localparam window_t W_LIMIT0 =
    '{CMIN_REAL_RST, CMIN_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 8'd0};
  localparam window_t W_LIMIT1 =
    '{CMIN_REAL_RST, CMIN_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 8'd1};
  localparam window_t W_SAT_HI =
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF, 8'd255};
  localparam window_t W_SAT_LO =
    '{32'sh8000_0000, 32'sh8000_0000, 28'd0, 28'd0, 8'd255};
  localparam window_t W_ORIGIN = '{32'sd0, 32'sd0, 28'd0, 28'd0, 8'd255};
  localparam window_t W_EDGE = '{-32'sd536870912, 32'sd0, 28'd1, 28'd0, 8'd255};
  localparam window_t W_SLOW =
    '{-32'sd201326592, 32'sd26843546, 28'd16384, 28'd16384, 8'd255};
  localparam window_t W_CUSP = '{32'sd67108864, 32'sd0, 28'd65536, 28'd65536, 8'd255};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  logic                 pixel_valid;
  logic                 pixel_ready;
  logic [COORD_W-1:0]   column;
  logic [COORD_W-1:0]   row;
  logic                 result_valid;
  logic                 result_ready;
  logic [LIMIT_W-1:0]   escape_count;

  logic signed [WORD_W-1:0] view_cmin_re;
  logic signed [WORD_W-1:0] view_cmin_im;
  logic [STEP_W-1:0]        view_step_re;
  logic [STEP_W-1:0]        view_step_im;
  logic [LIMIT_W-1:0]       view_limit;

  logic [LIMIT_W-1:0] pending_counts [$];
  pin_t               pins [$];
  probe_t             probes [$];
  int                 mismatches = 0;
  int                 results_seen = 0;
  bit                 gaps_on = 1'b1;
  bit                 stalls_on = 1'b1;

  mandelbrot_escape_time i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .column       (column),
    .row          (row),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .escape_count (escape_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint clamp_word(input longint x);
    if (x > WORD_MAX) begin
      return WORD_MAX;
    end
    if (x < WORD_MIN) begin
      return WORD_MIN;
    end
    return x;
  endfunction

  function automatic bit within_radius(input longint re, input longint im);
    logic [63:0] mag;
    mag = re * re + im * im;
    return mag < (64'd4 << (2 * FRAC_BITS));
  endfunction

  function automatic logic [LIMIT_W-1:0] escape_count_of(input logic [COORD_W-1:0] col,
                                                         input logic [COORD_W-1:0] rw);
    longint      c_re;
    longint      c_im;
    longint      re;
    longint      im;
    longint      nre;
    longint      nim;
    int unsigned lim;
    int unsigned n;
    c_re = clamp_word(view_cmin_re + longint'(col) * longint'(view_step_re));
    c_im = clamp_word(view_cmin_im + longint'(rw) * longint'(view_step_im));
    lim = (view_limit > ITER_CELLS) ? ITER_CELLS : view_limit;
    re = 0;
    im = 0;
    n = 0;
    while (n < lim && within_radius(re, im)) begin
      nre = ((re * re - im * im) >>> FRAC_BITS) + c_re;
      nim = ((re * im) >>> (FRAC_BITS - 1)) + c_im;
      re = clamp_word(nre);
      im = clamp_word(nim);
      n++;
    end
    return within_radius(re, im) ? '0 : n[LIMIT_W-1:0];
  endfunction

  function automatic window_t pick_window(input plan_kind_t plan);
    window_t w;
    w.cmin_re = WORD_W'($urandom_range(0, 671088640)) - 32'd603979776;
    w.cmin_im = WORD_W'($urandom_range(0, 536870912)) - 32'd402653184;
    w.step_re = STEP_W'($urandom_range(1, 787201));
    w.step_im = STEP_W'($urandom_range(1, 787201));
    w.limit = 8'd255;
    case (plan)
      PLAN_DEFAULT: begin
        w = W_RESET;
      end
      PLAN_NOISE: begin
        w.cmin_re = $urandom;
        w.cmin_im = $urandom;
        w.step_re = STEP_W'($urandom);
        w.step_im = STEP_W'($urandom);
        w.limit = LIMIT_W'($urandom_range(0, 255));
      end
      PLAN_ZOOM_ANY: begin
        w.limit = LIMIT_W'($urandom_range(1, 255));
      end
      PLAN_ZOOM_ONE: begin
        w.limit = 8'd1;
      end
      PLAN_ZOOM_SHALLOW: begin
        w.limit = LIMIT_W'($urandom_range(1, 32));
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  task automatic note_mismatch(input string what, input logic [LIMIT_W-1:0] want,
                               input logic [LIMIT_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s at result %0d: expected %0d, got %0d",
               $realtime, what, results_seen, want, got);
    end
  endtask

  task automatic apply_window(input window_t w);
    cfg_we <= 1'b1;
    cfg_index <= REG_CMIN_REAL;
    cfg_data <= w.cmin_re;
    @(posedge clk);
    cfg_index <= REG_CMIN_IMAG;
    cfg_data <= w.cmin_im;
    @(posedge clk);
    cfg_index <= REG_STEP_REAL;
    cfg_data <= WORD_W'(w.step_re);
    @(posedge clk);
    cfg_index <= REG_STEP_IMAG;
    cfg_data <= WORD_W'(w.step_im);
    @(posedge clk);
    cfg_index <= REG_ITER_LIMIT;
    cfg_data <= WORD_W'(w.limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_counts.size() != 0);
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw,
                            input logic pinned, input logic [LIMIT_W-1:0] count);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    column <= col;
    row <= rw;
    pins.push_back('{pinned, count});
    @(posedge clk);
    while (!pixel_ready) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_p
    logic [LIMIT_W-1:0] want;
    pin_t               pin;
    if (rst) begin
      view_cmin_re = CMIN_REAL_RST;
      view_cmin_im = CMIN_IMAG_RST;
      view_step_re = STEP_REAL_RST;
      view_step_im = STEP_IMAG_RST;
      view_limit = LIMIT_RST;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (pending_counts.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, escape_count);
        end else begin
          want = pending_counts.pop_front();
          if (escape_count !== want) begin
            note_mismatch("escape_count mismatch", want, escape_count);
          end
        end
      end
      if (pixel_valid && pixel_ready) begin
        pin = pins.pop_front();
        pending_counts.push_back(pin.pinned ? pin.count : escape_count_of(column, row));
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CMIN_REAL:  view_cmin_re = cfg_data;
          REG_CMIN_IMAG:  view_cmin_im = cfg_data;
          REG_STEP_REAL:  view_step_re = cfg_data[STEP_W-1:0];
          REG_STEP_IMAG:  view_step_im = cfg_data[STEP_W-1:0];
          REG_ITER_LIMIT: view_limit = cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  initial begin : sink_p
    result_ready = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) begin
      @(posedge clk);
    end
    forever begin
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stim_p
    probe_t  probe;
    window_t current;
    bit      configured;
    bit      last_phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_valid = 1'b0;
    column = '0;
    row = '0;
    configured = 1'b0;
    current = W_RESET;

    probes.push_back('{W_RESET, 10'd0, 10'd0, 1'b1, 8'd1});
    probes.push_back('{W_RESET, 10'd1023, 10'd1023, 1'b1, 8'd1});
    probes.push_back('{W_RESET, 10'd0, 10'd1023, 1'b1, 8'd1});
    probes.push_back('{W_RESET, 10'd1023, 10'd0, 1'b1, 8'd1});
    probes.push_back('{W_RESET, 10'd320, 10'd240, 1'b0, 8'd0});
    probes.push_back('{W_RESET, 10'd427, 10'd239, 1'b0, 8'd0});
    probes.push_back('{W_RESET, 10'd200, 10'd300, 1'b0, 8'd0});
    probes.push_back('{W_RESET, 10'd682, 10'd341, 1'b0, 8'd0});
    probes.push_back('{W_LIMIT0, 10'd0, 10'd0, 1'b1, 8'd0});
    probes.push_back('{W_LIMIT0, 10'd320, 10'd240, 1'b1, 8'd0});
    probes.push_back('{W_LIMIT1, 10'd0, 10'd0, 1'b1, 8'd1});
    probes.push_back('{W_LIMIT1, 10'd320, 10'd240, 1'b0, 8'd0});
    probes.push_back('{W_SAT_HI, 10'd1023, 10'd1023, 1'b1, 8'd1});
    probes.push_back('{W_SAT_HI, 10'd1, 10'd1, 1'b1, 8'd1});
    probes.push_back('{W_SAT_LO, 10'd0, 10'd0, 1'b1, 8'd1});
    probes.push_back('{W_SAT_LO, 10'd1023, 10'd1023, 1'b1, 8'd1});
    probes.push_back('{W_ORIGIN, 10'd0, 10'd0, 1'b1, 8'd0});
    probes.push_back('{W_ORIGIN, 10'd1023, 10'd1023, 1'b1, 8'd0});
    probes.push_back('{W_EDGE, 10'd0, 10'd0, 1'b1, 8'd1});
    probes.push_back('{W_EDGE, 10'd1, 10'd0, 1'b0, 8'd0});
    probes.push_back('{W_EDGE, 10'd511, 10'd0, 1'b0, 8'd0});
    probes.push_back('{W_SLOW, 10'd0, 10'd0, 1'b0, 8'd0});
    probes.push_back('{W_SLOW, 10'd37, 10'd19, 1'b0, 8'd0});
    probes.push_back('{W_CUSP, 10'd0, 10'd0, 1'b0, 8'd0});
    probes.push_back('{W_CUSP, 10'd3, 10'd1, 1'b0, 8'd0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) begin
      probe = probes[i];
      if (!configured || probe.win != current) begin
        drain_results();
        apply_window(probe.win);
        current = probe.win;
        configured = 1'b1;
      end
      send_pixel(probe.col, probe.rw, probe.pinned, probe.count);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      last_phase = (p == NUM_PHASES - 1);
      drain_results();
      apply_window(pick_window(PHASE_PLAN[p]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          gaps_on = !last_phase && ($urandom_range(0, 3) != 0);
          stalls_on = !last_phase && ($urandom_range(0, 3) != 0);
        end
        if (p == HOLD_PHASE && k == 60) begin
          drain_results();
        end
        send_pixel(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                   1'b0, '0);
      end
    end

    drain_results();
    repeat (LATENCY + 16) @(posedge clk);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("mandelbrot_escape_time regression: pass");
    end else begin
      $display("mandelbrot_escape_time regression: fail");
    end
    $finish;
  end

  initial begin : watchdog_p
    #2_000_000;
    $display("mandelbrot_escape_time regression: fail");
    $finish;
  end

endmodule
